// ----- rtl/ttb_pkg.sv -----
package ttb_pkg;

    // Event codes carried by an input item.
    typedef enum logic [1:0] {
        FUNC_TERM = 2'd0,
        FUNC_DISP = 2'd1,
        FUNC_CONN = 2'd2,
        FUNC_DISC = 2'd3
    } t_func;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_TERM  = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_RESET = 2'd3
    } t_kind;

    // Fixed message bursts held in the constant text store.
    typedef enum logic [3:0] {
        MSG_NONE       = 4'd0,
        MSG_NEG        = 4'd1,
        MSG_CLEAR      = 4'd2,
        MSG_RESET      = 4'd3,
        MSG_UC_OUT_ON  = 4'd4,
        MSG_UC_OUT_OFF = 4'd5,
        MSG_UC_IN_ON   = 4'd6,
        MSG_UC_IN_OFF  = 4'd7,
        MSG_EIGHT      = 4'd8,
        MSG_SEVEN      = 4'd9
    } t_msg;

    typedef struct packed {
        t_func      func;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] out_data;
        logic       key_raw;
        logic       last;
    } t_out_item;

    // One unit of work for the back end: an optional leading ESC key, an
    // optional message burst, then up to three explicit items.
    typedef struct packed {
        logic            pre_esc;
        logic            pre_raw;
        t_msg            msg;
        t_kind           tail_kind;
        logic            tail_raw;
        logic [1:0]      tail_cnt;
        logic [2:0][7:0] tail_data;
    } t_job;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_msg_item;

    localparam logic [7:0] BYTE_IAC  = 8'hFF;
    localparam logic [7:0] BYTE_WILL = 8'hFB;
    localparam logic [7:0] BYTE_WONT = 8'hFC;
    localparam logic [7:0] BYTE_DO   = 8'hFD;
    localparam logic [7:0] BYTE_DONT = 8'hFE;
    localparam logic [7:0] BYTE_ESC  = 8'h1B;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_LF   = 8'h0A;

    localparam int unsigned TXT_W = 8 * 17;

    localparam logic [TXT_W-1:0] TXT_NEG        = TXT_W'(72'hFFFB01_FFFB03_FFFD03);
    localparam logic [TXT_W-1:0] TXT_CLEAR      = TXT_W'("\033[2J\033[H");
    localparam logic [TXT_W-1:0] TXT_UC_OUT_ON  = TXT_W'("\015\n[UC OUT: ON]\015\n");
    localparam logic [TXT_W-1:0] TXT_UC_OUT_OFF = TXT_W'("\015\n[UC OUT: OFF]\015\n");
    localparam logic [TXT_W-1:0] TXT_UC_IN_ON   = TXT_W'("\015\n[UC IN: ON]\015\n");
    localparam logic [TXT_W-1:0] TXT_UC_IN_OFF  = TXT_W'("\015\n[UC IN: OFF]\015\n");
    localparam logic [TXT_W-1:0] TXT_EIGHT      = TXT_W'("\015\n[8-BIT MODE]\015\n");
    localparam logic [TXT_W-1:0] TXT_SEVEN      = TXT_W'("\015\n[7-BIT MODE]\015\n");

    // Number of items in a message burst.
    function automatic logic [4:0] msg_len(input t_msg m);
        logic [4:0] len;
        begin
            unique case (m)
                MSG_NEG:        len = 5'd9;
                MSG_CLEAR:      len = 5'd8;
                MSG_RESET:      len = 5'd1;
                MSG_UC_OUT_ON:  len = 5'd16;
                MSG_UC_OUT_OFF: len = 5'd17;
                MSG_UC_IN_ON:   len = 5'd15;
                MSG_UC_IN_OFF:  len = 5'd16;
                MSG_EIGHT:      len = 5'd16;
                MSG_SEVEN:      len = 5'd16;
                default:        len = 5'd0;
            endcase
            return len;
        end
    endfunction

    // Character idx of a right-aligned text of length len.
    function automatic logic [7:0] txt_byte(input logic [TXT_W-1:0] s,
                                            input logic [4:0] len,
                                            input logic [4:0] idx);
        logic [4:0]       pos;
        logic [TXT_W-1:0] sh;
        begin
            pos = len - idx - 5'd1;
            sh  = s >> {pos, 3'b000};
            return sh[7:0];
        end
    endfunction

    // Item idx of a message burst.
    function automatic t_msg_item msg_item(input t_msg m, input logic [4:0] idx);
        t_msg_item it;
        begin
            it.kind = KIND_TERM;
            it.data = 8'h00;
            unique case (m)
                MSG_NEG:        it.data = txt_byte(TXT_NEG, 5'd9, idx);
                MSG_CLEAR: begin
                    if (idx == 5'd7) begin
                        it.kind = KIND_CLEAR;
                    end else begin
                        it.data = txt_byte(TXT_CLEAR, 5'd7, idx);
                    end
                end
                MSG_RESET:      it.kind = KIND_RESET;
                MSG_UC_OUT_ON:  it.data = txt_byte(TXT_UC_OUT_ON, 5'd16, idx);
                MSG_UC_OUT_OFF: it.data = txt_byte(TXT_UC_OUT_OFF, 5'd17, idx);
                MSG_UC_IN_ON:   it.data = txt_byte(TXT_UC_IN_ON, 5'd15, idx);
                MSG_UC_IN_OFF:  it.data = txt_byte(TXT_UC_IN_OFF, 5'd16, idx);
                MSG_EIGHT:      it.data = txt_byte(TXT_EIGHT, 5'd16, idx);
                MSG_SEVEN:      it.data = txt_byte(TXT_SEVEN, 5'd16, idx);
                default:        it.data = 8'h00;
            endcase
            return it;
        end
    endfunction

endpackage

// ----- rtl/ttb_front.sv -----
module ttb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ttb_pkg::t_in_item  i_item,
    input  logic               i_full,
    output logic               o_stall,
    output logic               o_push,
    output ttb_pkg::t_job      o_job
);

    // Telnet receive parser phase.
    typedef enum logic [2:0] {
        PH_NORMAL = 3'b001,
        PH_IAC    = 3'b010,
        PH_VERB   = 3'b100
    } t_phase;

    // Local commands from ESC letters and control keys.
    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_CLEAR  = 3'd1,
        CMD_RESET  = 3'd2,
        CMD_UC_OUT = 3'd3,
        CMD_UC_IN  = 3'd4,
        CMD_WIDTH  = 3'd5
    } t_cmd;

    localparam logic [7:0] OPT_ECHO = 8'h01;
    localparam logic [7:0] OPT_SGA  = 8'h03;
    localparam logic [7:0] CTL_TAB  = 8'h09;
    localparam logic [7:0] CTL_FF   = 8'h0C;
    localparam logic [7:0] CTL_SI   = 8'h0F;
    localparam logic [7:0] CTL_DC2  = 8'h12;
    localparam logic [7:0] CTL_DC4  = 8'h14;

    function automatic t_cmd esc_map(input logic [7:0] b);
        t_cmd c;
        begin
            unique case (b) inside
                8'h54, 8'h74: c = CMD_WIDTH;
                8'h4F, 8'h6F: c = CMD_UC_OUT;
                8'h4C, 8'h6C: c = CMD_CLEAR;
                8'h52, 8'h72: c = CMD_RESET;
                8'h49, 8'h69: c = CMD_UC_IN;
                default:      c = CMD_NONE;
            endcase
            return c;
        end
    endfunction

    function automatic t_cmd ctl_map(input logic [7:0] b);
        t_cmd c;
        begin
            unique case (b)
                CTL_TAB: c = CMD_UC_IN;
                CTL_FF:  c = CMD_CLEAR;
                CTL_SI:  c = CMD_UC_OUT;
                CTL_DC2: c = CMD_RESET;
                default: c = CMD_NONE;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] k);
        begin
            if (k >= 8'h61 && k <= 8'h7A) begin
                return k ^ 8'h20;
            end
            return k;
        end
    endfunction

    t_phase     r_phase, n_phase;
    logic [7:0] r_verb, n_verb;
    logic       r_esc, n_esc;
    logic       r_eight, n_eight;
    logic       r_up_out, n_up_out;
    logic       r_up_in, n_up_in;
    logic       r_cr, n_cr;
    logic       r_conn, n_conn;

    ttb_pkg::t_job job;
    t_cmd          cmd;
    logic          proc;
    logic          go;
    logic          opt_ok;
    logic          accept;
    logic [7:0]    b;
    logic [7:0]    low;
    logic [7:0]    up_low;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign b       = i_item.data_byte;
    assign low     = {1'b0, b[6:0]};
    assign up_low  = r_up_in ? upcase(low) : low;
    assign opt_ok  = (b == OPT_ECHO) ? (r_verb == ttb_pkg::BYTE_DO) :
                     (b == OPT_SGA)  ? (r_verb == ttb_pkg::BYTE_WILL ||
                                        r_verb == ttb_pkg::BYTE_DO) : 1'b0;

    // Classify the item, work out the next mode state and the job for the back end.
    always_comb begin
        n_phase  = r_phase;
        n_verb   = r_verb;
        n_esc    = r_esc;
        n_eight  = r_eight;
        n_up_out = r_up_out;
        n_up_in  = r_up_in;
        n_cr     = r_cr;
        n_conn   = r_conn;
        job           = '0;
        job.msg       = ttb_pkg::MSG_NONE;
        job.tail_kind = ttb_pkg::KIND_TERM;
        cmd  = CMD_NONE;
        proc = 1'b0;
        go   = 1'b0;

        unique case (i_item.func)
            ttb_pkg::FUNC_TERM: begin
                if (r_conn) begin
                    // Telnet command parsing.
                    unique case (r_phase)
                        PH_IAC: begin
                            if (b >= ttb_pkg::BYTE_WILL && b <= ttb_pkg::BYTE_DONT) begin
                                n_verb  = b;
                                n_phase = PH_VERB;
                            end else begin
                                n_phase = PH_NORMAL;
                                proc    = (b == ttb_pkg::BYTE_IAC);
                            end
                        end
                        PH_VERB: begin
                            n_phase = PH_NORMAL;
                            if (!opt_ok && (r_verb == ttb_pkg::BYTE_WILL ||
                                            r_verb == ttb_pkg::BYTE_DO)) begin
                                job.tail_cnt     = 2'd3;
                                job.tail_data[0] = ttb_pkg::BYTE_IAC;
                                job.tail_data[1] = (r_verb == ttb_pkg::BYTE_WILL) ?
                                                   ttb_pkg::BYTE_DONT : ttb_pkg::BYTE_WONT;
                                job.tail_data[2] = b;
                            end
                        end
                        default: begin
                            n_phase = PH_NORMAL;
                            if (b == ttb_pkg::BYTE_IAC) begin
                                n_phase = PH_IAC;
                            end else begin
                                proc = 1'b1;
                            end
                        end
                    endcase

                    // Data byte: escape sequences, control keys and plain keys.
                    if (proc) begin
                        go = 1'b1;
                        if (r_esc) begin
                            n_esc = 1'b0;
                            cmd   = esc_map(b);
                            if (cmd != CMD_NONE) begin
                                go = 1'b0;
                            end else begin
                                job.pre_esc = 1'b1;
                                job.pre_raw = r_eight;
                            end
                        end else if (b == ttb_pkg::BYTE_ESC) begin
                            n_esc = 1'b1;
                            go    = 1'b0;
                        end
                        if (go) begin
                            if (b == CTL_DC4) begin
                                cmd = CMD_WIDTH;
                            end else if (!r_eight) begin
                                cmd = ctl_map(b);
                            end
                            if (cmd == CMD_NONE && b != ttb_pkg::BYTE_LF) begin
                                job.tail_kind    = ttb_pkg::KIND_KEY;
                                job.tail_raw     = r_eight;
                                job.tail_cnt     = 2'd1;
                                job.tail_data[0] = r_eight ? b :
                                                   (r_up_out ? upcase(low) : low);
                            end
                        end
                    end
                end
            end
            ttb_pkg::FUNC_DISP: begin
                if (r_conn) begin
                    if (r_eight) begin
                        // Raw display with CR held until the next byte.
                        if (b == 8'h00) begin
                            job.tail_cnt = 2'd0;
                        end else if (low == ttb_pkg::BYTE_LF) begin
                            if (r_cr) begin
                                n_cr             = 1'b0;
                                job.tail_cnt     = 2'd2;
                                job.tail_data[0] = ttb_pkg::BYTE_CR;
                                job.tail_data[1] = ttb_pkg::BYTE_LF;
                            end
                        end else if (low == ttb_pkg::BYTE_CR) begin
                            n_cr = 1'b1;
                        end else if (r_cr) begin
                            n_cr             = 1'b0;
                            job.tail_cnt     = 2'd3;
                            job.tail_data[0] = ttb_pkg::BYTE_CR;
                            job.tail_data[1] = ttb_pkg::BYTE_LF;
                            job.tail_data[2] = b;
                        end else begin
                            job.tail_cnt     = 2'd1;
                            job.tail_data[0] = b;
                        end
                    end else begin
                        // Seven-bit display: filter controls, expand CR.
                        if (low < 8'd32 && low != ttb_pkg::BYTE_CR &&
                            low != ttb_pkg::BYTE_ESC) begin
                            job.tail_cnt = 2'd0;
                        end else if (low == ttb_pkg::BYTE_CR) begin
                            job.tail_cnt     = 2'd2;
                            job.tail_data[0] = ttb_pkg::BYTE_CR;
                            job.tail_data[1] = ttb_pkg::BYTE_LF;
                        end else begin
                            job.tail_cnt     = 2'd1;
                            job.tail_data[0] = up_low;
                        end
                    end
                end
            end
            ttb_pkg::FUNC_CONN: begin
                n_conn  = 1'b1;
                n_phase = PH_NORMAL;
                n_esc   = 1'b0;
                n_cr    = 1'b0;
                job.msg = ttb_pkg::MSG_NEG;
            end
            default: begin
                n_conn = 1'b0;
            end
        endcase

        // Local commands pick their message; the mode commands also toggle their mode.
        unique case (cmd)
            CMD_CLEAR: job.msg = ttb_pkg::MSG_CLEAR;
            CMD_RESET: job.msg = ttb_pkg::MSG_RESET;
            CMD_UC_OUT: begin
                n_up_out = !r_up_out;
                job.msg  = n_up_out ? ttb_pkg::MSG_UC_OUT_ON : ttb_pkg::MSG_UC_OUT_OFF;
            end
            CMD_UC_IN: begin
                n_up_in = !r_up_in;
                job.msg = n_up_in ? ttb_pkg::MSG_UC_IN_ON : ttb_pkg::MSG_UC_IN_OFF;
            end
            CMD_WIDTH: begin
                n_eight = !r_eight;
                n_cr    = 1'b0;
                job.msg = n_eight ? ttb_pkg::MSG_EIGHT : ttb_pkg::MSG_SEVEN;
            end
            default: begin
                job.msg = job.msg;
            end
        endcase
    end

    // Only items that cause results go into the queue.
    assign o_job  = job;
    assign o_push = accept && (job.pre_esc || job.msg != ttb_pkg::MSG_NONE ||
                               job.tail_cnt != 2'd0);

    // Mode and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_NORMAL;
            r_verb   <= 8'h00;
            r_esc    <= 1'b0;
            r_eight  <= 1'b0;
            r_up_out <= 1'b1;
            r_up_in  <= 1'b0;
            r_cr     <= 1'b0;
            r_conn   <= 1'b0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_verb   <= n_verb;
            r_esc    <= n_esc;
            r_eight  <= n_eight;
            r_up_out <= n_up_out;
            r_up_in  <= n_up_in;
            r_cr     <= n_cr;
            r_conn   <= n_conn;
        end
    end

endmodule

// ----- rtl/ttb_queue.sv -----
module ttb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttb_pkg::t_job i_data,
    input  logic          i_pop,
    output ttb_pkg::t_job o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ttb_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign n_wr    = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd    = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("job pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job popped from an empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("queue count beyond depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

// ----- rtl/ttb_back.sv -----
module ttb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ttb_pkg::t_job      i_job,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    output ttb_pkg::t_out_item o_item,
    input  logic               i_stall
);

    // Sequencer over the parts of one job.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PRE  = 4'b0010,
        S_MSG  = 4'b0100,
        S_TAIL = 4'b1000
    } t_step;

    t_step              r_step, n_step;
    logic [4:0]         r_idx, n_idx;
    ttb_pkg::t_job      r_job;
    ttb_pkg::t_out_item r_out;
    logic               r_out_valid;

    ttb_pkg::t_out_item item;
    ttb_pkg::t_msg_item mitem;
    t_step              start_step;
    t_step              after_msg;
    logic               out_free;
    logic               emit;
    logic [7:0]         tail_byte;

    assign out_free = !r_out_valid || !i_stall;
    assign emit     = (r_step != S_IDLE) && out_free;
    assign o_pop    = (r_step == S_IDLE) && !i_empty;
    assign mitem    = ttb_pkg::msg_item(r_job.msg, r_idx);

    assign start_step = i_job.pre_esc ? S_PRE :
                        (i_job.msg != ttb_pkg::MSG_NONE) ? S_MSG : S_TAIL;
    assign after_msg  = (r_job.tail_cnt != 2'd0) ? S_TAIL : S_IDLE;

    // Tail byte selection.
    always_comb begin
        case (r_idx[1:0])
            2'd0:    tail_byte = r_job.tail_data[0];
            2'd1:    tail_byte = r_job.tail_data[1];
            default: tail_byte = r_job.tail_data[2];
        endcase
    end

    // Current item and the step after it.
    always_comb begin
        item.out_kind = ttb_pkg::KIND_TERM;
        item.out_data = 8'h00;
        item.key_raw  = 1'b0;
        n_step        = r_step;
        n_idx         = r_idx;
        unique case (r_step)
            S_PRE: begin
                item.out_kind = ttb_pkg::KIND_KEY;
                item.out_data = ttb_pkg::BYTE_ESC;
                item.key_raw  = r_job.pre_raw;
                n_idx         = 5'd0;
                n_step        = (r_job.msg != ttb_pkg::MSG_NONE) ? S_MSG : after_msg;
            end
            S_MSG: begin
                item.out_kind = mitem.kind;
                item.out_data = mitem.data;
                if (r_idx == ttb_pkg::msg_len(r_job.msg) - 5'd1) begin
                    n_idx  = 5'd0;
                    n_step = after_msg;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            S_TAIL: begin
                item.out_kind = r_job.tail_kind;
                item.out_data = tail_byte;
                item.key_raw  = r_job.tail_raw;
                if (r_idx[1:0] == r_job.tail_cnt - 2'd1) begin
                    n_idx  = 5'd0;
                    n_step = S_IDLE;
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            default: begin
                n_step = S_IDLE;
                n_idx  = 5'd0;
            end
        endcase
        item.last = (n_step == S_IDLE);
    end

    // Sequencer state and job register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
            r_idx  <= 5'd0;
        end else if (o_pop) begin
            r_step <= start_step;
            r_idx  <= 5'd0;
        end else if (emit) begin
            r_step <= n_step;
            r_idx  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ----- rtl/telnet_terminal_bridge_top.sv -----
// Telnet terminal bridge.
// Input channel (i_valid, i_item, o_stall): one event per item, a terminal
// byte, a CPU display byte, a client connect or a client disconnect.
// Output channel (o_valid, o_item, i_stall): bytes for the terminal, keys for
// the machine, and clear-screen or reset requests; last marks the final result
// of an input item. An item may cause no result at all.
// The front end parses telnet commands, escape and control keys, updates the
// modes as it accepts each item and queues a job; the back end expands each job
// from the queue into results at one per cycle while the output is not stalled,
// reading status texts from a constant table.
// The first result of an item passes the queue, the back end's job register
// and the output register. The front end takes a new item while the queue has
// room, before the jobs ahead of it are through; items that cause no result
// are not queued.
// Reset clears the parser and connection state, selects 7-bit mode with
// uppercase keys, and empties the queue and the output register.
// When the receiver stalls, the output item holds, the queue fills and then
// o_stall rises until the back end frees a slot.
module telnet_terminal_bridge_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  ttb_pkg::t_in_item  i_item,
    output logic               o_stall,
    output logic               o_valid,
    output ttb_pkg::t_out_item o_item,
    input  logic               i_stall
);

    ttb_pkg::t_job push_job;
    ttb_pkg::t_job head_job;
    logic          push;
    logic          pop;
    logic          full;
    logic          empty;

    ttb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .i_full  (full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_job   (push_job)
    );

    ttb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .i_pop   (pop),
        .o_data  (head_job),
        .o_full  (full),
        .o_empty (empty)
    );

    ttb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_stall (i_stall)
    );

endmodule
